[src/sfsc_pkg.sv]
// Package for the sensor frame sum and CRC block: types, constants and CRC helpers.
package sfsc_pkg;

  // Frame variant codes as held in the variant register.
  typedef enum logic [1:0] {
    VAR_TEN   = 2'd0,
    VAR_EIGHT = 2'd1,
    VAR_SHORT = 2'd2,
    VAR_SPARE = 2'd3
  } variant_t;

  // Configuration register indexes.
  localparam logic CFG_IDX_VARIANT = 1'b0;
  localparam logic CFG_IDX_POLY    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [1:0] VARIANT_RESET = 2'd0;
  localparam logic [7:0] POLY_RESET    = 8'h07;

  // Initial CRC values for each variant.
  localparam logic [7:0] CRC_INIT_TEN   = 8'h00;
  localparam logic [7:0] CRC_INIT_EIGHT = 8'h3C;
  localparam logic [7:0] CRC_INIT_SHORT = 8'hD6;

  // Index of the final byte for each variant.
  localparam logic [3:0] LAST_IDX_TEN   = 4'd9;
  localparam logic [3:0] LAST_IDX_EIGHT = 4'd7;
  localparam logic [3:0] LAST_IDX_SHORT = 4'd5;

  // Byte positions whose nibbles are kept out of the CRC.
  localparam logic [3:0] POS_SKIP_HI = 4'd3;
  localparam logic [3:0] POS_SKIP_LO = 4'd2;

  // Four MSB-first shift steps of the CRC with the given polynomial.
  function automatic logic [7:0] crc_shift4(input logic [7:0] crc_in,
                                            input logic [7:0] poly);
    logic [7:0] c;
    c = crc_in;
    for (int k = 0; k < 4; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Exchange the two nibbles of a byte.
  function automatic logic [7:0] swap_nibbles(input logic [7:0] v);
    return {v[3:0], v[7:4]};
  endfunction

  // Initial CRC for a raw variant code; the spare code acts as the ten-byte frame.
  function automatic logic [7:0] crc_init(input logic [1:0] code);
    logic [7:0] r;
    case (variant_t'(code))
      VAR_EIGHT: r = CRC_INIT_EIGHT;
      VAR_SHORT: r = CRC_INIT_SHORT;
      default:   r = CRC_INIT_TEN;
    endcase
    return r;
  endfunction

  // Final byte index for a raw variant code.
  function automatic logic [3:0] last_index(input logic [1:0] code);
    logic [3:0] r;
    case (variant_t'(code))
      VAR_EIGHT: r = LAST_IDX_EIGHT;
      VAR_SHORT: r = LAST_IDX_SHORT;
      default:   r = LAST_IDX_TEN;
    endcase
    return r;
  endfunction

endpackage

[src/sensor_frame_sum_and_crc.sv]
// Sensor frame check generator: nibble sum and nibble-serial CRC-8 over one frame.
//
// Usage: payload bytes enter on the in_ channel (valid/ready), one byte per item, with
// in_frame_start marking byte 0 of a new frame. Each byte is folded into an 8-bit
// wrapping nibble sum and an 8-bit CRC within the cycle it is accepted. On the final
// byte of the selected frame variant one result item leaves on the out_ channel with
// the packed check bytes, the final sum and the final CRC; other bytes give no item.
// Throughput is one byte per cycle unless a result item waits with out_ready low, set by
// the single combinational CRC update between the state registers and the result register.
// The result is valid in the cycle after its final byte is accepted.
// The result register parts the two sides: while it holds an item that is not taken,
// in_ready stays high if out_ready is high and falls otherwise, so a stalled receiver
// holds the sender only when a result is waiting.
// Write configuration through cfg_we/cfg_index/cfg_wdata only while the block is idle; it is not enforced.
// A variant write discards any partial frame; a polynomial write leaves state alone.
// Reset (synchronous, rst_n low) selects the ten-byte variant, polynomial 0x07 and
// clears position, sum, CRC and the result valid flag.
module sensor_frame_sum_and_crc
  import sfsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // Configuration write port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  // Input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_payload_byte,
  input  logic       in_frame_start,
  // Result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_check_byte_first,
  output logic [7:0] out_check_byte_second,
  output logic [7:0] out_check_byte_third,
  output logic [7:0] out_sum_value,
  output logic [7:0] out_crc_value
);

  // Configuration and frame state.
  logic [1:0] variant_r;
  logic [7:0] poly_r;
  logic [3:0] pos_r,  pos_nxt;
  logic [7:0] sum_r,  sum_nxt;
  logic [7:0] crc_r,  crc_nxt;

  // Result register.
  logic       out_valid_r;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic [7:0] third_r, third_nxt;
  logic [7:0] osum_r, osum_nxt;
  logic [7:0] ocrc_r, ocrc_nxt;

  logic       in_acc;
  logic       is_short;
  logic       is_final;
  logic [3:0] base_pos;
  logic [7:0] base_sum;
  logic [7:0] base_crc;
  logic [7:0] byte_m;
  logic [7:0] sum_upd;
  logic [7:0] crc_hi;
  logic [7:0] crc_lo;
  logic [7:0] crc_end;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign is_short = (variant_t'(variant_r) == VAR_SHORT);

  // Fold one byte into the sum and CRC.
  always_comb begin
    base_pos = in_frame_start ? 4'd0 : pos_r;
    base_sum = in_frame_start ? 8'd0 : sum_r;
    base_crc = in_frame_start ? crc_init(variant_r) : crc_r;
    is_final = (base_pos >= last_index(variant_r));
    // In the long variants the final byte's low nibble counts as zero.
    byte_m   = (is_final && !is_short) ? {in_payload_byte[7:4], 4'h0} : in_payload_byte;
    sum_upd  = base_sum + {4'h0, byte_m[7:4]} + {4'h0, byte_m[3:0]};
    crc_hi   = (base_pos != POS_SKIP_HI) ?
               crc_shift4(base_crc ^ {4'h0, byte_m[7:4]}, poly_r) : base_crc;
    crc_lo   = (base_pos != POS_SKIP_LO) ?
               crc_shift4(crc_hi ^ {4'h0, byte_m[3:0]}, poly_r) : crc_hi;
    crc_end  = is_short ? crc_shift4(crc_lo, poly_r) : crc_lo;
  end

  // Pack the check bytes for the result.
  always_comb begin
    osum_nxt = sum_upd;
    ocrc_nxt = crc_end;
    if (is_short) begin
      first_nxt  = swap_nibbles(sum_upd);
      second_nxt = swap_nibbles(crc_end);
      third_nxt  = 8'h00;
    end else begin
      first_nxt  = {byte_m[7:4], sum_upd[3:0]};
      second_nxt = {sum_upd[7:4], crc_end[3:0]};
      third_nxt  = {crc_end[7:4], 4'h0};
    end
  end

  // Next frame state: restart after the final byte.
  always_comb begin
    if (is_final) begin
      pos_nxt = 4'd0;
      sum_nxt = 8'd0;
      crc_nxt = crc_init(variant_r);
    end else begin
      pos_nxt = base_pos + 4'd1;
      sum_nxt = sum_upd;
      crc_nxt = crc_lo;
    end
  end

  // Configuration registers and frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= VARIANT_RESET;
      poly_r    <= POLY_RESET;
      pos_r     <= 4'd0;
      sum_r     <= 8'd0;
      crc_r     <= crc_init(VARIANT_RESET);
    end else if (cfg_we && cfg_index == CFG_IDX_VARIANT) begin
      variant_r <= cfg_wdata[1:0];
      pos_r     <= 4'd0;
      sum_r     <= 8'd0;
      crc_r     <= crc_init(cfg_wdata[1:0]);
    end else begin
      if (cfg_we && cfg_index == CFG_IDX_POLY) begin
        poly_r <= cfg_wdata;
      end
      if (in_acc) begin
        pos_r <= pos_nxt;
        sum_r <= sum_nxt;
        crc_r <= crc_nxt;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && is_final) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_acc && is_final) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      third_r  <= third_nxt;
      osum_r   <= osum_nxt;
      ocrc_r   <= ocrc_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_check_byte_first  = first_r;
  assign out_check_byte_second = second_r;
  assign out_check_byte_third  = third_r;
  assign out_sum_value         = osum_r;
  assign out_crc_value         = ocrc_r;

endmodule

[src/sfsc_checker.sv]
// Port-level checker for the sensor frame sum and CRC block, with its bind statement.
module sfsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_check_byte_first,
  input logic [7:0] out_check_byte_second,
  input logic [7:0] out_check_byte_third,
  input logic [7:0] out_sum_value
);

  // A waiting result item stays until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // With no result waiting the block is always ready to take a byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // A result item appears only in the cycle after an accepted byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> $past(in_valid && in_ready))
    else $error("result item without an accepted byte");

  // The check bytes always carry the sum in one of the two packings.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_check_byte_third[3:0] == 4'h0) &&
      ((out_check_byte_first[3:0] == out_sum_value[3:0] &&
        out_check_byte_second[7:4] == out_sum_value[7:4]) ||
       (out_check_byte_first[7:4] == out_sum_value[3:0] &&
        out_check_byte_first[3:0] == out_sum_value[7:4] &&
        out_check_byte_third == 8'h00)))
    else $error("check bytes inconsistent with sum");

endmodule

bind sensor_frame_sum_and_crc sfsc_checker u_sfsc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_check_byte_first  (out_check_byte_first),
  .out_check_byte_second (out_check_byte_second),
  .out_check_byte_third  (out_check_byte_third),
  .out_sum_value         (out_sum_value)
);
